### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each check is clocked on the rising
// edge and held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

### rtl/tksb_pkg.sv
`default_nettype none

package tksb_pkg;

  localparam int SCORE_W = 32;
  localparam int PORT_TAG_W = 16;
  localparam int PORT_RANK_W = 4;
  localparam int PORT_CNT_W = 4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic signed [SCORE_W-1:0]    new_score;
    logic [PORT_TAG_W-1:0]        name_tag;
  } in_t;

  typedef struct packed {
    logic                         kind;
    logic [PORT_RANK_W-1:0]       rank;
    logic                         entry_valid;
    logic                         dropped;
    logic signed [SCORE_W-1:0]    out_score;
    logic [PORT_TAG_W-1:0]        out_tag;
    logic [PORT_CNT_W-1:0]        entry_count;
    logic                         last;
  } out_t;

  // Per-cell control from the board sequencer
  typedef struct packed {
    logic ins;        // insert transaction this cycle
    logic rot;        // rotate toward the head during read out
    logic take_prev;  // left neighbor yields its slot, shift its entry in
    logic wrap;       // last occupied cell: pull the head entry on rotate
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/top_k_score_board.sv
`default_nettype none
// Ranked score board, sorted by descending score, newest first among ties.
// Input: drive in_data and raise start; the transaction is taken at an edge
// where start is high and busy is low.
// Insert (mode 0): one report appears on out_data with out_strobe in the cycle
// after acceptance. busy stays low, so an insert can be taken every cycle.
// All cells compare against the new score at once; the cells after the insertion
// point shift their entries one place toward the tail in the same edge.
// Read (mode 1): the held entries stream out one per cycle, rank order; busy
// (rd_active_r) is set on acceptance and each result is registered in out_r.
// busy stays high while the occupied cells rotate toward the head, and the last
// result carries last = 1. A read of an empty board gives one result next cycle.
// Results stand on the ports for one cycle only; the receiver must take each
// one when out_strobe is high, it cannot hold them off.
// Reset (rst_n low, synchronous) empties the board; entry payloads keep no
// reset value and are never shown before they are written.

`include "assert_macros.svh"

module top_k_score_board
  import tksb_pkg::*;
#(
  parameter int DEPTH     = 10,
  parameter int TAG_WIDTH = 16
) (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  output logic  busy,
  input  in_t   in_data,
  output logic  out_strobe,
  output out_t  out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int TX = (TAG_WIDTH > PORT_TAG_W) ? TAG_WIDTH : PORT_TAG_W;
  localparam int RX = (CW > PORT_RANK_W) ? CW : PORT_RANK_W;

  logic [DEPTH-1:0]           vl;
  logic [DEPTH-1:0]           take;
  logic signed [SCORE_W-1:0]  sc [DEPTH];
  logic [TAG_WIDTH-1:0]       tg [DEPTH];

  logic [CW-1:0]  count_r, count_nxt;
  logic           rd_active_r, rd_active_nxt;
  logic [CW-1:0]  rd_idx_r, rd_idx_nxt;
  logic           out_strobe_r, out_strobe_nxt;
  out_t           out_r, out_nxt;

  logic                ins_go, rd_go, full, kept;
  logic [TX-1:0]       tag_in_x, drop_tag_x, head_tag_x;
  logic [TAG_WIDTH-1:0] new_tag;
  logic [CW-1:0]       pos, cnt_after;
  logic [RX-1:0]       pos_x, cnt_x, idx_x, cnt_now_x;

  assign busy   = rd_active_r;
  assign ins_go = start && !busy && (in_data.mode == MODE_INSERT);
  assign rd_go  = start && !busy && (in_data.mode == MODE_READ);

  assign tag_in_x = TX'(in_data.name_tag);
  assign new_tag  = tag_in_x[TAG_WIDTH-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : i - 1;
    localparam int N = (i == DEPTH - 1) ? 0 : i + 1;
    cell_ctl_t ctl;

    assign ctl.ins       = ins_go;
    assign ctl.rot       = rd_active_r && (CW'(i) < count_r);
    assign ctl.take_prev = (i == 0) ? 1'b0 : take[P];
    assign ctl.wrap      = (CW'(i) == count_r - CW'(1));

    tksb_cell #(
      .TAG_WIDTH(TAG_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_score  (in_data.new_score),
      .new_tag    (new_tag),
      .prev_valid (vl[P]),
      .prev_score (sc[P]),
      .prev_tag   (tg[P]),
      .next_valid (vl[N]),
      .next_score (sc[N]),
      .next_tag   (tg[N]),
      .head_valid (vl[0]),
      .head_score (sc[0]),
      .head_tag   (tg[0]),
      .valid_o    (vl[i]),
      .score_o    (sc[i]),
      .tag_o      (tg[i]),
      .take_o     (take[i])
    );
  end

  assign full = vl[DEPTH-1];
  // take is monotonic along the row, so the tail cell tells whether any slot opens
  assign kept = take[DEPTH-1];

  always_comb begin
    logic [CW-1:0] acc;
    acc = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (take[i] && ((i == 0) || !take[(i == 0) ? 0 : i - 1])) begin
        acc = acc | CW'(i);
      end
    end
    pos = kept ? acc : CW'(DEPTH);
  end

  assign cnt_after  = full ? count_r : count_r + CW'(1);
  assign pos_x      = RX'(pos);
  assign cnt_x      = RX'(cnt_after);
  assign cnt_now_x  = RX'(count_r);
  assign idx_x      = RX'(rd_idx_r);
  assign drop_tag_x = kept ? TX'(tg[DEPTH-1]) : TX'(new_tag);
  assign head_tag_x = TX'(tg[0]);

  always_comb begin
    count_nxt      = count_r;
    rd_active_nxt  = rd_active_r;
    rd_idx_nxt     = rd_idx_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    if (ins_go) begin
      count_nxt            = cnt_after;
      out_strobe_nxt       = 1'b1;
      out_nxt.kind         = KIND_INSERT;
      out_nxt.rank         = pos_x[PORT_RANK_W-1:0];
      out_nxt.entry_valid  = 1'b0;
      out_nxt.dropped      = full;
      out_nxt.out_score    = full ? (kept ? sc[DEPTH-1] : in_data.new_score) : '0;
      out_nxt.out_tag      = full ? drop_tag_x[PORT_TAG_W-1:0] : '0;
      out_nxt.entry_count  = cnt_x[PORT_CNT_W-1:0];
      out_nxt.last         = 1'b1;
    end else if (rd_go) begin
      if (count_r == '0) begin
        out_strobe_nxt       = 1'b1;
        out_nxt.kind         = KIND_ENTRY;
        out_nxt.rank         = '0;
        out_nxt.entry_valid  = 1'b0;
        out_nxt.dropped      = 1'b0;
        out_nxt.out_score    = '0;
        out_nxt.out_tag      = '0;
        out_nxt.entry_count  = '0;
        out_nxt.last         = 1'b1;
      end else begin
        rd_active_nxt = 1'b1;
        rd_idx_nxt    = '0;
      end
    end else if (rd_active_r) begin
      // emit the head cell while the occupied cells rotate under it
      out_strobe_nxt       = 1'b1;
      out_nxt.kind         = KIND_ENTRY;
      out_nxt.rank         = idx_x[PORT_RANK_W-1:0];
      out_nxt.entry_valid  = 1'b1;
      out_nxt.dropped      = 1'b0;
      out_nxt.out_score    = sc[0];
      out_nxt.out_tag      = head_tag_x[PORT_TAG_W-1:0];
      out_nxt.entry_count  = cnt_now_x[PORT_CNT_W-1:0];
      out_nxt.last         = (rd_idx_r == count_r - CW'(1));
      rd_idx_nxt           = rd_idx_r + CW'(1);
      if (rd_idx_r == count_r - CW'(1)) begin
        rd_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      rd_active_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      rd_active_r  <= rd_active_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    out_r    <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

  `ASSERT_PROP(a_busy_nonempty, clk, rst_n, rd_active_r |-> (count_r != '0))
  `ASSERT_PROP(a_valid_matches_count, clk, rst_n, ($countones(vl) == int'(count_r)))
  `ASSERT_PROP(a_insert_reports, clk, rst_n,
               ins_go |=> (out_strobe_r && out_r.last && (out_r.kind == KIND_INSERT)))
  `ASSERT_NEVER(a_read_last_busy, clk, rst_n,
                out_strobe_r && (out_r.kind == KIND_ENTRY) && out_r.last && rd_active_r)

endmodule

`default_nettype wire

### rtl/tksb_cell.sv
`default_nettype none

module tksb_cell
  import tksb_pkg::*;
#(
  parameter int TAG_WIDTH = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  cell_ctl_t                  ctl,
  input  wire signed [SCORE_W-1:0]   new_score,
  input  wire [TAG_WIDTH-1:0]        new_tag,
  input  wire                        prev_valid,
  input  wire signed [SCORE_W-1:0]   prev_score,
  input  wire [TAG_WIDTH-1:0]        prev_tag,
  input  wire                        next_valid,
  input  wire signed [SCORE_W-1:0]   next_score,
  input  wire [TAG_WIDTH-1:0]        next_tag,
  input  wire                        head_valid,
  input  wire signed [SCORE_W-1:0]   head_score,
  input  wire [TAG_WIDTH-1:0]        head_tag,
  output logic                       valid_o,
  output logic signed [SCORE_W-1:0]  score_o,
  output logic [TAG_WIDTH-1:0]       tag_o,
  output logic                       take_o
);

  logic                       valid_r, valid_nxt;
  logic signed [SCORE_W-1:0]  score_r, score_nxt;
  logic [TAG_WIDTH-1:0]       tag_r, tag_nxt;

  // Free slot, or held score not above the new one: new entry goes here or earlier
  assign take_o = !valid_r || (score_r <= new_score);

  always_comb begin
    valid_nxt = valid_r;
    score_nxt = score_r;
    tag_nxt   = tag_r;
    if (ctl.ins) begin
      if (ctl.take_prev) begin
        valid_nxt = prev_valid;
        score_nxt = prev_score;
        tag_nxt   = prev_tag;
      end else if (take_o) begin
        valid_nxt = 1'b1;
        score_nxt = new_score;
        tag_nxt   = new_tag;
      end
    end else if (ctl.rot) begin
      if (ctl.wrap) begin
        valid_nxt = head_valid;
        score_nxt = head_score;
        tag_nxt   = head_tag;
      end else begin
        valid_nxt = next_valid;
        score_nxt = next_score;
        tag_nxt   = next_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    tag_r   <= tag_nxt;
  end

  assign valid_o = valid_r;
  assign score_o = score_r;
  assign tag_o   = tag_r;

endmodule

`default_nettype wire

### test/top_k_score_board_tb.sv
`timescale 1ns / 100ps

module top_k_score_board_tb;
  import tksb_pkg::*;

  localparam int BOARD_DEPTH  = 10;
  localparam int RANDOM_ITEMS = 350;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_strobe;
  out_t out_data;

  top_k_score_board #(
    .DEPTH(BOARD_DEPTH),
    .TAG_WIDTH(PORT_TAG_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_strobe(out_strobe),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the board, ranked by descending score
  logic signed [SCORE_W-1:0] board_score [BOARD_DEPTH];
  logic [PORT_TAG_W-1:0]     board_tag [BOARD_DEPTH];
  int                        board_count = 0;

  out_t board_reports_q [$];
  out_t front_report;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   burst_left = 1;

  function automatic void apply_to_board(input in_t item);
    out_t r;
    int   slot;
    r = '0;
    if (item.mode == MODE_READ) begin
      r.kind = KIND_ENTRY;
      if (board_count == 0) begin
        r.last = 1'b1;
        board_reports_q.push_back(r);
      end else begin
        for (int i = 0; i < board_count; i++) begin
          r.rank        = PORT_RANK_W'(i);
          r.entry_valid = 1'b1;
          r.out_score   = board_score[i];
          r.out_tag     = board_tag[i];
          r.entry_count = PORT_CNT_W'(board_count);
          r.last        = (i == board_count - 1);
          board_reports_q.push_back(r);
        end
      end
      return;
    end

    // first held entry not above the new score; scan backward so the lowest wins
    slot = board_count;
    for (int i = board_count - 1; i >= 0; i--)
      if ($signed(board_score[i]) <= $signed(item.new_score)) slot = i;

    r.kind = KIND_INSERT;
    r.last = 1'b1;
    if (slot >= BOARD_DEPTH) begin
      // full board, new entry below everything: it falls off itself
      r.rank      = PORT_RANK_W'(BOARD_DEPTH);
      r.dropped   = 1'b1;
      r.out_score = item.new_score;
      r.out_tag   = item.name_tag;
    end else begin
      if (board_count == BOARD_DEPTH) begin
        r.dropped   = 1'b1;
        r.out_score = board_score[BOARD_DEPTH-1];
        r.out_tag   = board_tag[BOARD_DEPTH-1];
      end else begin
        board_count++;
      end
      for (int i = board_count - 1; i > slot; i--) begin
        board_score[i] = board_score[i-1];
        board_tag[i]   = board_tag[i-1];
      end
      board_score[slot] = item.new_score;
      board_tag[slot]   = item.name_tag;
      r.rank = PORT_RANK_W'(slot);
    end
    r.entry_count = PORT_CNT_W'(board_count);
    board_reports_q.push_back(r);
  endfunction

  // Predict on every accepted transaction
  always @(posedge clk) begin
    if (rst_n && start && !busy) apply_to_board(in_data);
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (board_reports_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: %h", out_data);
        mismatch_count++;
      end else begin
        front_report = board_reports_q.pop_front();
        if (out_data.kind !== front_report.kind ||
            out_data.rank !== front_report.rank ||
            out_data.entry_valid !== front_report.entry_valid ||
            out_data.dropped !== front_report.dropped ||
            out_data.out_score !== front_report.out_score ||
            out_data.out_tag !== front_report.out_tag ||
            out_data.entry_count !== front_report.entry_count ||
            out_data.last !== front_report.last) begin
          if (mismatch_count < 10)
            $display({"mismatch: want kind %0d rank %0d valid %0d drop %0d score %0d ",
                      "tag %h count %0d last %0d; got kind %0d rank %0d valid %0d ",
                      "drop %0d score %0d tag %h count %0d last %0d"},
                     front_report.kind, front_report.rank, front_report.entry_valid,
                     front_report.dropped, front_report.out_score, front_report.out_tag,
                     front_report.entry_count, front_report.last,
                     out_data.kind, out_data.rank, out_data.entry_valid,
                     out_data.dropped, out_data.out_score, out_data.out_tag,
                     out_data.entry_count, out_data.last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("top_k_score_board_tb NOT OK");
      $finish;
    end
  end

  function automatic in_t board_item(input logic mode, input logic signed [SCORE_W-1:0] score,
                                     input logic [PORT_TAG_W-1:0] tag);
    in_t item;
    item.mode      = mode;
    item.new_score = score;
    item.name_tag  = tag;
    return item;
  endfunction

  // Hold the transaction until taken, then idle between bursts
  task automatic send_item(input in_t item);
    int          gap;
    logic [63:0] junk;
    in_data <= item;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      junk = {$urandom, $urandom};
      start   <= 1'b0;
      in_data <= junk[$bits(in_t)-1:0];
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    logic signed [SCORE_W-1:0] s;
    s = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4: begin
        s = $urandom_range(0, 32);
        s = s - 16;
      end
      5, 6, 7: begin
        // land on or next to a held score to stress ties and the board end
        if (board_count > 0) begin
          s = board_score[$urandom_range(0, board_count - 1)];
          s = s + $urandom_range(0, 2) - 1;
        end
      end
      default: begin
        case ($urandom_range(0, 3))
          0: s = SCORE_MAX;
          1: s = SCORE_MIN;
          2: s = '0;
          default: s = -1;
        endcase
      end
    endcase
    return s;
  endfunction

  task automatic test_empty_board();
    send_item(board_item(MODE_READ, SCORE_MAX, 16'hFFFF));
  endtask

  task automatic test_fill_and_ties();
    send_item(board_item(MODE_INSERT, 0, 16'h0001));
    send_item(board_item(MODE_INSERT, SCORE_MAX, 16'hFFFF));
    send_item(board_item(MODE_INSERT, SCORE_MIN, 16'h0000));
    send_item(board_item(MODE_INSERT, -1, 16'h0004));
    send_item(board_item(MODE_INSERT, 1, 16'h0005));
    send_item(board_item(MODE_INSERT, 0, 16'h0006));
    send_item(board_item(MODE_READ, 0, 16'h0000));
    send_item(board_item(MODE_INSERT, SCORE_MAX, 16'h0008));
    send_item(board_item(MODE_INSERT, SCORE_MIN, 16'h8000));
    send_item(board_item(MODE_INSERT, 100, 16'h000A));
    send_item(board_item(MODE_INSERT, -100, 16'h000B));
    send_item(board_item(MODE_READ, SCORE_MIN, 16'h5A5A));
  endtask

  task automatic test_full_board_drops();
    // old last entry falls off
    send_item(board_item(MODE_INSERT, 5, 16'h0010));
    // tie with the last entry: goes ahead of it and pushes it off
    send_item(board_item(MODE_INSERT, SCORE_MIN, 16'h0011));
    send_item(board_item(MODE_INSERT, 50, 16'h0012));
    // below everything held: the new entry is the one dropped
    send_item(board_item(MODE_INSERT, SCORE_MIN, 16'hA5A5));
    send_item(board_item(MODE_INSERT, -100, 16'h0014));
    send_item(board_item(MODE_READ, -1, 16'hFFFF));
  endtask

  task automatic test_random_traffic();
    in_t item;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      item.mode      = ($urandom_range(0, 7) == 0) ? MODE_READ : MODE_INSERT;
      item.new_score = pick_score();
      item.name_tag  = PORT_TAG_W'($urandom_range(0, 16'hFFFF));
      send_item(item);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_board();
    test_fill_and_ties();
    test_full_board_drops();
    test_random_traffic();
    start <= 1'b0;
    @(posedge clk);
    while (board_reports_q.size() != 0) @(posedge clk);
    repeat (BOARD_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0 && board_reports_q.size() == 0)
      $display("top_k_score_board_tb OK");
    else
      $display("top_k_score_board_tb NOT OK");
    $finish;
  end

endmodule
